@@ rtl/tcce_pkg.sv @@
package tcce_pkg;

	// screen geometry limits
	localparam int MAX_COLS   = 80;
	localparam int MAX_ROWS   = 25;
	localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	// fixed field widths
	localparam int OP_W      = 2;
	localparam int CHAR_W    = 8;
	localparam int COL_W     = 7;
	localparam int ROW_W     = 5;
	localparam int IDX_W     = 11;
	localparam int CELL_W    = 16;
	localparam int NIB_W     = 4;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_FG = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_BG = 2'd3;

	// character codes
	localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TOP    = 8'h7F;
	localparam logic [COL_W-1:0]  TAB_STEP  = 7'd8;

	localparam logic [CELL_W-1:0] INIT_CELL = 16'h0F20;

	// reset geometry and colours
	localparam logic [COL_W-1:0] RST_COLS = COL_W'(MAX_COLS);
	localparam logic [ROW_W-1:0] RST_ROWS = ROW_W'(MAX_ROWS);
	localparam logic [NIB_W-1:0] RST_FG   = 4'hF;
	localparam logic [NIB_W-1:0] RST_BG   = 4'h0;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [CHAR_W-1:0] char_code;
		logic [IDX_W-1:0]  cell_index;
	} cmd_t;

	typedef struct packed {
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic [IDX_W-1:0]  cursor_index;
		logic [CELL_W-1:0] cell_data;
	} rsp_t;

endpackage

@@ rtl/tcce_ram.sv @@
module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/text_console_char_engine_top.sv @@
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+------------------------------------
// cmd      | in        | cmd_valid / cmd_stall | op, char_code, cell_index
// rsp      | out       | rsp_valid / rsp_stall | cursor_col, cursor_row, cursor_index,
//          |           |                       | cell_data
// cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one command word at a time, all screen traffic through a single dual-port cell ram
// plain put character passes the execute state; read cell adds the read and done states (registered ram read)
// clear: columns*rows ram writes, one cell written per cycle
// scroll: (rows-1)*columns cell copies, then columns blank writes
// after reset a clearing pass fills all 2000 cells of the ram; cmd_stall is held meanwhile
// a waiting rsp word does not block the next command; the engine only waits when it
// has a new result and the output register is still full
module text_console_char_engine_top
	import tcce_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_t                 cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {
		ST_FILL,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_COPY,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration, geometry already clamped to the usable range
	logic [COL_W-1:0] ncols_q;
	logic [ROW_W-1:0] nrows_q;
	logic [NIB_W-1:0] fg_q;
	logic [NIB_W-1:0] bg_q;

	// geometry products, refreshed every cycle
	logic [ADDR_W-1:0] area_q;
	logic [ADDR_W-1:0] lastbase_q;

	logic [COL_W-1:0] cur_col_q;
	logic [ROW_W-1:0] cur_row_q;
	cmd_t             item_q;
	rsp_t             res_q;
	rsp_t             out_q;
	logic             out_valid_q;

	// fill sweep (reset clearing pass, clear screen, blank bottom line)
	logic [ADDR_W-1:0] fill_ptr_q;
	logic [ADDR_W-1:0] fill_last_q;
	logic [CELL_W-1:0] fill_data_q;
	logic              init_q;

	// scroll copy: read one line ahead, write back in the following cycle
	logic [ADDR_W-1:0] cp_rd_q;
	logic              cp_vld_s1;
	logic [ADDR_W-1:0] cp_addr_s1;
	logic              rd_zero_q;

	logic [CELL_W-1:0] blank;
	logic              out_free;

	// execute stage logic
	logic [COL_W-1:0]  col_s;
	logic [ROW_W-1:0]  row_s;
	logic [COL_W-1:0]  col_n;
	logic [ROW_W-1:0]  row_n;
	logic [COL_W-1:0]  col_f;
	logic [ROW_W-1:0]  row_f;
	logic              scroll;
	logic              put_we;
	logic [COL_W-1:0]  put_col;
	logic [CELL_W-1:0] put_data;
	logic [ADDR_W-1:0] row_base;
	logic [ADDR_W-1:0] put_addr;
	logic [ADDR_W-1:0] idx_full;
	logic              read_ok;
	logic              cp_more;
	rsp_t              res_n;

	// ram ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	assign cfg_ready = 1'b1;
	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign blank    = {bg_q, fg_q, CH_SPACE};
	assign out_free = !out_valid_q || !rsp_stall;
	assign cp_more  = (cp_rd_q < lastbase_q);

	// register writes, zero geometry acts as one and oversize as the maximum; rows looks only at the low five data bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncols_q <= RST_COLS;
			nrows_q <= RST_ROWS;
			fg_q    <= RST_FG;
			bg_q    <= RST_BG;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COLUMNS: begin
					if (cfg_data == '0) begin
						ncols_q <= COL_W'(1);
					end else if (cfg_data > CFG_W'(MAX_COLS)) begin
						ncols_q <= COL_W'(MAX_COLS);
					end else begin
						ncols_q <= cfg_data[COL_W-1:0];
					end
				end
				REG_ROWS: begin
					if (cfg_data[ROW_W-1:0] == '0) begin
						nrows_q <= ROW_W'(1);
					end else if (cfg_data[ROW_W-1:0] > ROW_W'(MAX_ROWS)) begin
						nrows_q <= ROW_W'(MAX_ROWS);
					end else begin
						nrows_q <= cfg_data[ROW_W-1:0];
					end
				end
				REG_TEXT_FG: fg_q <= cfg_data[NIB_W-1:0];
				REG_TEXT_BG: bg_q <= cfg_data[NIB_W-1:0];
				default: ;
			endcase
		end
	end

	// the user may change config only while idle; the block itself does not enforce it. The products here are registered
	always_ff @(posedge clk) begin
		area_q     <= ADDR_W'(nrows_q) * ADDR_W'(ncols_q);
		lastbase_q <= ADDR_W'(nrows_q - ROW_W'(1)) * ADDR_W'(ncols_q);
	end

	// execute: saturate the cursor, apply the character, wrap and detect scroll
	always_comb begin
		col_s    = (cur_col_q >= ncols_q) ? ncols_q - COL_W'(1) : cur_col_q;
		row_s    = (cur_row_q >= nrows_q) ? nrows_q - ROW_W'(1) : cur_row_q;
		col_n    = col_s;
		row_n    = row_s;
		put_we   = 1'b0;
		put_col  = col_s;
		put_data = blank;
		scroll   = 1'b0;

		if (item_q.char_code == CH_BS) begin
			if (col_s != '0) begin
				col_n = col_s - COL_W'(1);
			end
			put_we  = 1'b1;
			put_col = col_n;
		end else if (item_q.char_code == CH_TAB) begin
			col_n = (col_s + TAB_STEP) & ~(TAB_STEP - COL_W'(1));
		end else if (item_q.char_code == CH_CR) begin
			col_n = '0;
		end else if (item_q.char_code == CH_LF) begin
			col_n = '0;
			row_n = row_s + ROW_W'(1);
		end else if (item_q.char_code >= CH_SPACE && item_q.char_code <= CH_TOP) begin
			put_we   = 1'b1;
			put_data = {bg_q, fg_q, item_q.char_code};
			col_n    = col_s + COL_W'(1);
		end

		// wrap past the last column
		if (col_n >= ncols_q) begin
			col_n = '0;
			row_n = row_n + ROW_W'(1);
		end
		// scroll past the last row
		if (row_n >= nrows_q) begin
			scroll = 1'b1;
			row_n  = nrows_q - ROW_W'(1);
		end

		case (item_q.op)
			OP_PUT: begin
				col_f = col_n;
				row_f = row_n;
			end
			OP_CLEAR: begin
				col_f = '0;
				row_f = '0;
			end
			default: begin
				col_f = col_s;
				row_f = row_s;
			end
		endcase

		row_base = ADDR_W'(row_s) * ADDR_W'(ncols_q);
		put_addr = row_base + ADDR_W'(put_col);
		idx_full = ADDR_W'(row_f) * ADDR_W'(ncols_q) + ADDR_W'(col_f);
		read_ok  = (item_q.cell_index < IDX_W'(CELL_COUNT));

		res_n.cursor_col   = col_f;
		res_n.cursor_row   = row_f;
		res_n.cursor_index = IDX_W'(idx_full);
		res_n.cell_data    = '0;
	end

	// ram port selection by state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		case (state_q)
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = fill_ptr_q;
				ram_wdata = fill_data_q;
			end
			ST_EXEC: begin
				if (item_q.op == OP_PUT && put_we) begin
					ram_we    = 1'b1;
					ram_waddr = put_addr;
					ram_wdata = put_data;
				end
				ram_raddr = item_q.cell_index[ADDR_W-1:0];
			end
			ST_COPY: begin
				// source is one line below the destination
				ram_raddr = cp_rd_q + ADDR_W'(ncols_q);
				if (cp_vld_s1) begin
					ram_we    = 1'b1;
					ram_waddr = cp_addr_s1;
					ram_wdata = ram_rdata;
				end
			end
			default: ;
		endcase
	end

	tcce_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer with cursor and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			item_q      <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			fill_ptr_q  <= '0;
			fill_last_q <= ADDR_W'(CELL_COUNT - 1);
			fill_data_q <= INIT_CELL;
			init_q      <= 1'b1;
			cp_rd_q     <= '0;
			cp_vld_s1   <= 1'b0;
			cp_addr_s1  <= '0;
			rd_zero_q   <= 1'b0;
		end else begin
			if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_FILL: begin
					fill_ptr_q <= fill_ptr_q + ADDR_W'(1);
					if (fill_ptr_q == fill_last_q) begin
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_DONE;
					end
				end

				ST_IDLE: begin
					if (cmd_valid) begin
						item_q  <= cmd;
						state_q <= ST_EXEC;
					end
				end

				ST_EXEC: begin
					cur_col_q <= col_f;
					cur_row_q <= row_f;
					res_q     <= res_n;
					case (item_q.op)
						OP_CLEAR: begin
							fill_ptr_q  <= '0;
							fill_last_q <= area_q - ADDR_W'(1);
							fill_data_q <= blank;
							state_q     <= ST_FILL;
						end
						OP_READ: begin
							rd_zero_q <= !read_ok;
							state_q   <= ST_READ;
						end
						OP_PUT: begin
							if (scroll) begin
								cp_rd_q   <= '0;
								cp_vld_s1 <= 1'b0;
								state_q   <= ST_COPY;
							end else if (out_free) begin
								out_q       <= res_n;
								out_valid_q <= 1'b1;
								state_q     <= ST_IDLE;
							end else begin
								state_q <= ST_DONE;
							end
						end
						default: begin
							if (out_free) begin
								out_q       <= res_n;
								out_valid_q <= 1'b1;
								state_q     <= ST_IDLE;
							end else begin
								state_q <= ST_DONE;
							end
						end
					endcase
				end

				ST_READ: begin
					res_q.cell_data <= rd_zero_q ? '0 : ram_rdata;
					state_q         <= ST_DONE;
				end

				ST_COPY: begin
					if (cp_more) begin
						cp_vld_s1  <= 1'b1;
						cp_addr_s1 <= cp_rd_q;
						cp_rd_q    <= cp_rd_q + ADDR_W'(1);
					end else begin
						cp_vld_s1 <= 1'b0;
						// last write has landed, blank the bottom line
						if (!cp_vld_s1) begin
							fill_ptr_q  <= lastbase_q;
							fill_last_q <= area_q - ADDR_W'(1);
							fill_data_q <= blank;
							state_q     <= ST_FILL;
						end
					end
				end

				ST_DONE: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/tcce_checker.sv @@
module tcce_assertions
	import tcce_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input cmd_t cmd,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a stalled rsp word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp word changed while stalled");

	// one command at a time: the engine is busy right after taking a word
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("second cmd word taken back to back");

	// cursor stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.cursor_col < COL_W'(MAX_COLS) && rsp.cursor_row < ROW_W'(MAX_ROWS))
		else $error("cursor outside the screen");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.cursor_index < IDX_W'(CELL_COUNT))
		else $error("cursor index outside the cell store");

endmodule

bind text_console_char_engine_top tcce_assertions u_tcce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
